@@ hdl/assert_macros.svh @@
// Shared assertion macros for the response framer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`endif

@@ hdl/mrf_pkg.sv @@
package mrf_pkg;

   localparam int FRAME_LEN = 7;
   localparam int CRC_SPAN  = 5;
   localparam int POS_W     = $clog2(FRAME_LEN);

   localparam logic [15:0] CRC_INIT   = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'hA001;
   localparam logic [7:0]  BYTE_COUNT = 8'd2;

   localparam logic [POS_W-1:0] POS_ADDR   = POS_W'(0);
   localparam logic [POS_W-1:0] POS_FUNC   = POS_W'(1);
   localparam logic [POS_W-1:0] POS_COUNT  = POS_W'(2);
   localparam logic [POS_W-1:0] POS_HI     = POS_W'(3);
   localparam logic [POS_W-1:0] POS_LO     = POS_W'(4);
   localparam logic [POS_W-1:0] POS_CRC_LO = POS_W'(5);
   localparam logic [POS_W-1:0] POS_CRC_HI = POS_W'(6);

   typedef struct packed {
      logic [7:0]  slave_address;
      logic [7:0]  function_code;
      logic [15:0] register_value;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
   } rsp_type;

   typedef struct packed {
      req_type     req;
      logic [15:0] crc;
   } beat_type;

   function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                            input logic [7:0]  data);
      logic [15:0] c;
      c = crc_in ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   function automatic logic [7:0] frame_pick(input beat_type b,
                                             input logic [POS_W-1:0] pos);
      logic [7:0] r;
      case (pos)
         POS_ADDR:   r = b.req.slave_address;
         POS_FUNC:   r = b.req.function_code;
         POS_COUNT:  r = BYTE_COUNT;
         POS_HI:     r = b.req.register_value[15:8];
         POS_LO:     r = b.req.register_value[7:0];
         POS_CRC_LO: r = b.crc[7:0];
         POS_CRC_HI: r = b.crc[15:8];
         default:    r = 8'h00;
      endcase
      return r;
   endfunction

endpackage

@@ hdl/mrf_crc_stage.sv @@
`include "assert_macros.svh"

module mrf_crc_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  mrf_pkg::beat_type in_beat,
   input  logic [7:0]        in_byte,
   output logic              out_valid,
   input  logic              out_ready,
   output mrf_pkg::beat_type out_beat
);

   logic              valid_ff;
   logic              valid_in;
   mrf_pkg::beat_type beat_ff;
   mrf_pkg::beat_type beat_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in    = in_ready ? in_valid : valid_ff;
      beat_in.req = in_beat.req;
      beat_in.crc = mrf_pkg::crc_feed(in_beat.crc, in_byte);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         beat_ff <= beat_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

   `ASSERT_NEXT(a_stall_holds, clock, reset, valid_ff && !out_ready,
                valid_ff && $stable(beat_ff))
   `ASSERT_NEXT(a_take_sets_valid, clock, reset, in_valid && in_ready, valid_ff)
   `ASSERT_IMPL(a_ready_when_empty, clock, reset, !valid_ff, in_ready)

endmodule

@@ hdl/mrf_serializer.sv @@
`include "assert_macros.svh"

module mrf_serializer (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  mrf_pkg::beat_type in_beat,
   output logic              rsp_strobe,
   output mrf_pkg::rsp_type  rsp_item
);

   localparam logic [mrf_pkg::POS_W-1:0] LAST_POS = mrf_pkg::POS_CRC_HI;

   logic                        active_ff;
   logic                        active_in;
   logic [mrf_pkg::POS_W-1:0]   pos_ff;
   logic [mrf_pkg::POS_W-1:0]   pos_in;
   mrf_pkg::beat_type           beat_ff;
   logic                        load;

   assign in_ready = !active_ff || (pos_ff == LAST_POS);
   assign load     = in_ready && in_valid;

   always_comb begin
      active_in = active_ff;
      pos_in    = pos_ff;
      if (load) begin
         active_in = 1'b1;
         pos_in    = mrf_pkg::POS_ADDR;
      end else if (active_ff) begin
         if (pos_ff == LAST_POS) begin
            active_in = 1'b0;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pos_ff    <= mrf_pkg::POS_ADDR;
      end else begin
         active_ff <= active_in;
         pos_ff    <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         beat_ff <= in_beat;
      end
   end

   assign rsp_strobe          = active_ff;
   assign rsp_item.frame_byte = mrf_pkg::frame_pick(beat_ff, pos_ff);
   assign rsp_item.last_byte  = active_ff && (pos_ff == LAST_POS);

   `ASSERT_NEXT(a_frame_contiguous, clock, reset, active_ff && pos_ff != LAST_POS,
                active_ff && pos_ff == $past(pos_ff) + 1'b1)
   `ASSERT_NEXT(a_restart_at_head, clock, reset, active_ff && pos_ff == LAST_POS,
                !active_ff || pos_ff == mrf_pkg::POS_ADDR)
   `ASSERT_IMPL(a_idle_no_last, clock, reset, !active_ff, !rsp_item.last_byte)

endmodule

@@ hdl/modbus_rtu_response_framer.sv @@
// A taken request passes the five CRC stages, then the serializer sends its bytes.
// The serializer sends one byte a cycle, taking a new request at a frame's last byte.
// Requests queue in the five CRC stages (one byte per stage) while a frame goes out.
// Reset (synchronous, active high) empties every stage; no frame is in flight after it.
// The receiver cannot stall: rsp_strobe marks each byte for exactly one cycle.
module modbus_rtu_response_framer (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  mrf_pkg::req_type req_item,
   output logic             rsp_strobe,
   output mrf_pkg::rsp_type rsp_item
);

   localparam int NSTG = mrf_pkg::CRC_SPAN;

   logic              stg_valid [NSTG+1];
   logic              stg_ready [NSTG+1];
   mrf_pkg::beat_type stg_beat  [NSTG+1];

   assign stg_valid[0]    = start;
   assign stg_beat[0].req = req_item;
   assign stg_beat[0].crc = mrf_pkg::CRC_INIT;
   assign busy            = !stg_ready[0];

   for (genvar k = 0; k < NSTG; k++) begin : g_crc
      mrf_crc_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stg_valid[k]),
         .in_ready  (stg_ready[k]),
         .in_beat   (stg_beat[k]),
         .in_byte   (mrf_pkg::frame_pick(stg_beat[k], mrf_pkg::POS_W'(k))),
         .out_valid (stg_valid[k+1]),
         .out_ready (stg_ready[k+1]),
         .out_beat  (stg_beat[k+1])
      );
   end

   mrf_serializer u_ser (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (stg_valid[NSTG]),
      .in_ready   (stg_ready[NSTG]),
      .in_beat    (stg_beat[NSTG]),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule
